// ----- hdl/mbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mbf_pkg
// Types and constants shared by the metaball field evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package mbf_pkg;

	localparam int NUM_BALLS = 5;
	localparam int CNT_W     = (NUM_BALLS > 1) ? $clog2(NUM_BALLS) : 1;
	localparam int POS_W     = 24;
	localparam int QUO_W     = 40;
	localparam int DIV_W     = 50;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_MOVE  = 2'd1;
	localparam logic [1:0] OP_EVAL  = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	localparam logic [7:0] ROWS_RST = 8'd100;
	localparam logic [7:0] COLS_RST = 8'd133;
	localparam logic [DIV_W-1:0] EPS = DIV_W'(7) << 16;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [2:0]       ball_index;
		logic [POS_W-1:0] load_x;
		logic [POS_W-1:0] load_y;
		logic signed [3:0] load_vel_x;
		logic signed [3:0] load_vel_y;
		logic [3:0]       load_radius;
		logic [15:0]      frame_time;
		logic [7:0]       cell_row;
		logic [7:0]       cell_col;
	} in_word_t;

	typedef struct packed {
		logic [31:0] field_value;
		logic [1:0]  op_done;
	} out_word_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [3:0]       vx;
		logic [3:0]       vy;
		logic [3:0]       r;
	} ball_t;

endpackage
`default_nettype wire

// ----- hdl/mbf_cell.sv -----
// ----------------------------------------------------------------------------
// mbf_cell
// One ball store of the ring; takes a load or its neighbour's ball.
// ----------------------------------------------------------------------------
`default_nettype none
module mbf_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          ld,
	input  wire mbf_pkg::ball_t ld_ball,
	input  wire logic          shift,
	input  wire mbf_pkg::ball_t nxt_ball,
	output mbf_pkg::ball_t     ball
);
	mbf_pkg::ball_t ball_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_q <= '0;
		end else if (ld) begin
			ball_q <= ld_ball;
		end else if (shift) begin
			ball_q <= nxt_ball;
		end
	end

	assign ball = ball_q;
endmodule
`default_nettype wire

// ----- hdl/mbf_mover.sv -----
// ----------------------------------------------------------------------------
// mbf_mover
// Bounce and move one ball by a frame time.
// ----------------------------------------------------------------------------
`default_nettype none
module mbf_mover (
	input  wire mbf_pkg::ball_t ball_in,
	input  wire logic [7:0]     rows_lim,
	input  wire logic [7:0]     cols_lim,
	input  wire logic [15:0]    dt,
	output mbf_pkg::ball_t      ball_out
);
	function automatic logic [27:0] axis(input logic [23:0] p, input logic [3:0] v,
			input logic [3:0] r, input logic [7:0] lim, input logic [15:0] t);
		logic signed [8:0]  hi_c;
		logic signed [25:0] hi;
		logic signed [25:0] ps;
		logic [3:0]         nv;
		logic signed [20:0] step;
		logic signed [25:0] np;
		logic [23:0]        res;
		hi_c = $signed({1'b0, lim}) - $signed({5'b0, r});
		hi   = 26'(hi_c) <<< 16;
		ps   = $signed({2'b0, p});
		nv   = ((p <= {4'b0, r, 16'b0}) || (ps >= hi)) ? 4'(-v) : v;
		step = $signed(nv) * $signed({1'b0, t});
		np   = ps + 26'(step);
		if (np < 0) res = '0;
		else if (np > 26'sh0FFFFFF) res = 24'hFFFFFF;
		else res = np[23:0];
		return {res, nv};
	endfunction

	logic [27:0] ax, ay;

	always_comb begin
		ax = axis(ball_in.x, ball_in.vx, ball_in.r, cols_lim, dt);
		ay = axis(ball_in.y, ball_in.vy, ball_in.r, rows_lim, dt);
		ball_out    = ball_in;
		ball_out.x  = ax[27:4];
		ball_out.vx = ax[3:0];
		ball_out.y  = ay[27:4];
		ball_out.vy = ay[3:0];
	end
endmodule
`default_nettype wire

// ----- hdl/mbf_term.sv -----
// ----------------------------------------------------------------------------
// mbf_term
// Field term of one ball: r^2 / (dx^2 + dy^2 + eps), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mbf_term (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire mbf_pkg::ball_t ball,
	input  wire logic [7:0]     row,
	input  wire logic [7:0]     col,
	output logic                done,
	output logic [mbf_pkg::QUO_W-1:0] quo
);
	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_SQ   = 4'b0010,
		T_SUM  = 4'b0100,
		T_DIV  = 4'b1000
	} tstate_t;

	tstate_t tstate_q;
	logic [23:0] adx_q, ady_q;
	logic [7:0]  r2_q;
	logic [47:0] dx2_q, dy2_q;
	logic [mbf_pkg::DIV_W-1:0] d_q;
	logic [mbf_pkg::DIV_W:0]   rem_q;
	logic [mbf_pkg::QUO_W-1:0] quo_q;
	logic [mbf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic done_q;
	logic signed [24:0] dx, dy;
	logic [mbf_pkg::DIV_W+1:0] sh;
	logic [mbf_pkg::DIV_W+1:0] diff;

	always_comb begin
		dx   = $signed({1'b0, col, 16'b0}) - $signed({1'b0, ball.x});
		dy   = $signed({1'b0, row, 16'b0}) - $signed({1'b0, ball.y});
		sh   = {rem_q, 1'b0};
		diff = sh - {2'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q <= T_IDLE;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (tstate_q)
				T_IDLE: if (start) tstate_q <= T_SQ;
				T_SQ:   tstate_q <= T_SUM;
				T_SUM: begin
					tstate_q <= T_DIV;
					cnt_q    <= '0;
				end
				T_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == mbf_pkg::DIV_CNT_W'(mbf_pkg::QUO_W - 1)) begin
						tstate_q <= T_IDLE;
						done_q   <= 1'b1;
					end
				end
				default: tstate_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tstate_q == T_IDLE && start) begin
			adx_q <= dx[24] ? 24'(-dx) : dx[23:0];
			ady_q <= dy[24] ? 24'(-dy) : dy[23:0];
			r2_q  <= 8'(ball.r * ball.r);
		end
		if (tstate_q == T_SQ) begin
			dx2_q <= adx_q * adx_q;
			dy2_q <= ady_q * ady_q;
		end
		if (tstate_q == T_SUM) begin
			d_q   <= {2'b0, dx2_q} + {2'b0, dy2_q} + mbf_pkg::EPS;
			rem_q <= (mbf_pkg::DIV_W+1)'({r2_q, 8'b0});
			quo_q <= '0;
		end
		if (tstate_q == T_DIV) begin
			if (!diff[mbf_pkg::DIV_W+1]) begin
				rem_q <= diff[mbf_pkg::DIV_W:0];
				quo_q <= {quo_q[mbf_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[mbf_pkg::DIV_W:0];
				quo_q <= {quo_q[mbf_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ----- hdl/metaball_field_evaluator.sv -----
// ----------------------------------------------------------------------------
// metaball_field_evaluator
// Ball ring with a shared mover and a shared bit-serial field divider.
// ----------------------------------------------------------------------------
// A load or an unused opcode answers in the cycle after it is taken. A
// frame advance rotates the ball ring once before it answers. A field
// query works the balls in turn, each with one start, one square, one
// sum, a 40-bit restoring division in the shared divider and one
// handover. One word is worked on at a time; the next is taken once the
// result has been handed on.
`default_nettype none
module metaball_field_evaluator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire mbf_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output mbf_pkg::out_word_t      out_word,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ADV  = 4'b0010,
		S_FLD  = 4'b0100,
		S_WAIT = 4'b1000
	} state_t;

	state_t state_q;
	mbf_pkg::in_word_t word_q;
	logic [7:0] rows_q, cols_q;
	logic [mbf_pkg::CNT_W-1:0] cnt_q;
	logic [31:0] acc_q;
	logic out_valid_q;
	mbf_pkg::out_word_t out_q;

	mbf_pkg::ball_t cells[mbf_pkg::NUM_BALLS];
	mbf_pkg::ball_t moved, tail_in, ld_ball;
	logic shift, accept, ld_any, t_done, last;
	logic [mbf_pkg::QUO_W-1:0] quo;
	logic [32:0] sum;
	logic [31:0] acc_n;

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign last      = (cnt_q == mbf_pkg::CNT_W'(mbf_pkg::NUM_BALLS - 1));
	assign shift     = (state_q == S_ADV) || t_done;
	assign tail_in   = (state_q == S_ADV) ? moved : cells[0];
	assign ld_any    = accept && (in_word.opcode == mbf_pkg::OP_LOAD);

	always_comb begin
		ld_ball.x  = in_word.load_x;
		ld_ball.y  = in_word.load_y;
		ld_ball.vx = in_word.load_vel_x;
		ld_ball.vy = in_word.load_vel_y;
		ld_ball.r  = in_word.load_radius;
		sum   = {1'b0, acc_q} + {1'b0, quo[31:0]};
		acc_n = (sum[32] || (quo[mbf_pkg::QUO_W-1:32] != '0)) ? '1 : sum[31:0];
	end

	for (genvar k = 0; k < mbf_pkg::NUM_BALLS; k++) begin : g_cell
		if (k == mbf_pkg::NUM_BALLS - 1) begin : g_tail
			mbf_cell u_cell (.clk, .arst_n,
				.ld(ld_any && (32'(in_word.ball_index) == k)), .ld_ball,
				.shift, .nxt_ball(tail_in), .ball(cells[k]));
		end else begin : g_mid
			mbf_cell u_cell (.clk, .arst_n,
				.ld(ld_any && (32'(in_word.ball_index) == k)), .ld_ball,
				.shift, .nxt_ball(cells[k+1]), .ball(cells[k]));
		end
	end

	mbf_mover u_mover (.ball_in(cells[0]), .rows_lim(rows_q), .cols_lim(cols_q),
		.dt(word_q.frame_time), .ball_out(moved));

	mbf_term u_term (.clk, .arst_n, .start(state_q == S_FLD), .ball(cells[0]),
		.row(word_q.cell_row), .col(word_q.cell_col), .done(t_done), .quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_q      <= mbf_pkg::ROWS_RST;
			cols_q      <= mbf_pkg::COLS_RST;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mbf_pkg::CFG_ROWS: rows_q <= cfg_data;
					mbf_pkg::CFG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (in_word.opcode == mbf_pkg::OP_MOVE) state_q <= S_ADV;
						else if (in_word.opcode == mbf_pkg::OP_EVAL) state_q <= S_FLD;
						else out_valid_q <= 1'b1;
					end
				end
				S_ADV: begin
					if (last) begin
						state_q     <= S_IDLE;
						cnt_q       <= '0;
						out_valid_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FLD: state_q <= S_WAIT;
				S_WAIT: begin
					if (t_done) begin
						if (last) begin
							state_q     <= S_IDLE;
							cnt_q       <= '0;
							out_valid_q <= 1'b1;
						end else begin
							state_q <= S_FLD;
							cnt_q   <= cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= in_word;
			acc_q  <= '0;
			out_q.field_value <= '0;
			out_q.op_done     <= in_word.opcode;
		end
		if (t_done) begin
			acc_q <= acc_n;
			if (last) out_q.field_value <= acc_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (in_stall && !out_valid))
		else $error("busy without stall");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		t_done |-> (state_q == S_WAIT))
		else $error("divider finished outside wait");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mbf_pkg::CNT_W'(mbf_pkg::NUM_BALLS - 1))
		else $error("ball count out of range");
	a_start_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLD) |=> (state_q == S_WAIT))
		else $error("field start lost");
endmodule
`default_nettype wire
